FILE: design/rsa_pkg.sv
`timescale 1ns / 1ps
// Shared package for the region sector allocator: status and request codes,
// geometry constants and the beat structs passed between modules. No dependencies.
package rsa_pkg;

    localparam int MAX_SECTORS  = 4096;
    localparam int GRID_SIZE    = 32;
    localparam int SECTOR_SHIFT = 12;
    localparam int SECTOR_SIZE  = 1 << SECTOR_SHIFT;
    localparam int HEADER_BYTES = 8;
    localparam int CNT_LIMIT    = 256;

    // request kinds
    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_WRITE  = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    // result status codes
    localparam logic [3:0] ST_REWRITE   = 4'd0;
    localparam logic [3:0] ST_REUSE     = 4'd1;
    localparam logic [3:0] ST_GROW      = 4'd2;
    localparam logic [3:0] ST_TOO_LARGE = 4'd3;
    localparam logic [3:0] ST_MISS      = 4'd4;
    localparam logic [3:0] ST_INVALID   = 4'd5;
    localparam logic [3:0] ST_OOB       = 4'd6;
    localparam logic [3:0] ST_NO_SPACE  = 4'd7;
    localparam logic [3:0] ST_LOADED    = 4'd8;
    localparam logic [3:0] ST_FOUND     = 4'd9;

    typedef struct packed {
        logic [1:0]        req_type;
        logic signed [7:0] chunk_x;
        logic signed [7:0] chunk_z;
        logic [31:0]       entry_word;
        logic [23:0]       comp_length;
    } req_t;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] start_sector;
        logic [7:0]  sector_count;
        logic [7:0]  grown_sectors;
    } res_t;

endpackage

FILE: design/rsa_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module rsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/rsa_seq.sv
`timescale 1ns / 1ps
// Request sequencer: clearing pass, table read-modify-write, free-map marking
// and first-fit scan. Depends on rsa_pkg; drives the two rsa_ram instances.
module rsa_seq #(
    parameter int MAX_SECTORS = rsa_pkg::MAX_SECTORS,
    parameter int GRID_SIZE   = rsa_pkg::GRID_SIZE,
    localparam int TBL_DEPTH  = GRID_SIZE * GRID_SIZE,
    localparam int TBL_AW     = $clog2(TBL_DEPTH),
    localparam int SECT_AW    = $clog2(MAX_SECTORS),
    localparam int FS_W       = SECT_AW + 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_we,
    input  logic [12:0]        cfg_wdata,
    // request side
    input  logic               in_valid,
    output logic               in_ready,
    input  rsa_pkg::req_t      in_req,
    // result side
    output logic               res_valid,
    input  logic               res_ready,
    output rsa_pkg::res_t      res,
    // offset table RAM
    output logic               tb_we,
    output logic [TBL_AW-1:0]  tb_waddr,
    output logic [31:0]        tb_wdata,
    output logic [TBL_AW-1:0]  tb_raddr,
    input  logic [31:0]        tb_rdata,
    // free map RAM
    output logic               fm_we,
    output logic [SECT_AW-1:0] fm_waddr,
    output logic               fm_wdata,
    output logic [SECT_AW-1:0] fm_raddr,
    input  logic               fm_rdata
);

    localparam int CLR_N = (MAX_SECTORS > TBL_DEPTH) ? MAX_SECTORS : TBL_DEPTH;
    localparam int CLR_W = $clog2(CLR_N) + 1;

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_MARK = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_RESP = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          ret_reg, ret_next;
    logic [CLR_W-1:0]    clr_reg, clr_next;
    logic [FS_W-1:0]     file_reg, file_next;
    rsa_pkg::req_t       req_reg, req_next;
    logic [TBL_AW-1:0]   idx_reg, idx_next;
    logic [31:0]         word_reg, word_next;
    logic                freed_reg, freed_next;
    logic [FS_W-1:0]     mark_addr_reg, mark_addr_next;
    logic [7:0]          mark_left_reg, mark_left_next;
    logic                mark_val_reg, mark_val_next;
    logic [FS_W-1:0]     scan_idx_reg, scan_idx_next;
    logic                pend_reg, pend_next;
    logic [FS_W-1:0]     pend_idx_reg, pend_idx_next;
    logic [FS_W-1:0]     run_start_reg, run_start_next;
    logic [7:0]          run_len_reg, run_len_next;
    rsa_pkg::res_t       res_reg, res_next;

    // request decode
    logic                in_oob;
    logic [15:0]         in_idx_full;
    logic [24:0]         need_full;
    logic [7:0]          needed;
    logic                too_large;
    logic [23:0]         old_start;
    logic [7:0]          old_cnt;
    logic                old_ok;
    logic                ent_ok;
    logic [FS_W-1:0]     run_start_c;
    logic [8:0]          run_len_c;
    logic [23:0]         start24;
    logic [31:0]         grow_sum;

    assign in_oob = in_req.chunk_x[7] || in_req.chunk_z[7]
                 || ({1'b0, in_req.chunk_x[6:0]} >= 8'(GRID_SIZE))
                 || ({1'b0, in_req.chunk_z[6:0]} >= 8'(GRID_SIZE));
    assign in_idx_full = {8'd0, in_req.chunk_z} * 16'(GRID_SIZE) + {8'd0, in_req.chunk_x};

    // sectors needed = (length + header) / sector size + 1
    assign need_full = (({1'b0, req_reg.comp_length} + 25'(rsa_pkg::HEADER_BYTES))
                       >> rsa_pkg::SECTOR_SHIFT) + 25'd1;
    assign too_large = need_full >= 25'(rsa_pkg::CNT_LIMIT);
    assign needed    = need_full[7:0];

    // range checks against the current file size
    assign old_start = tb_rdata[31:8];
    assign old_cnt   = tb_rdata[7:0];
    assign old_ok    = (tb_rdata != 32'd0)
                    && ({1'b0, old_start} + {17'd0, old_cnt} <= 25'(file_reg));
    assign ent_ok    = (req_reg.entry_word != 32'd0)
                    && ({1'b0, req_reg.entry_word[31:8]} + {17'd0, req_reg.entry_word[7:0]}
                        <= 25'(file_reg));

    assign run_start_c = (run_len_reg == 8'd0) ? pend_idx_reg : run_start_reg;
    assign run_len_c   = {1'b0, run_len_reg} + 9'd1;
    assign grow_sum    = 32'(file_reg) + 32'(needed);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_RESP);
    assign res       = res_reg;

    // next-state and memory port logic
    always_comb begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        clr_next       = clr_reg;
        file_next      = file_reg;
        req_next       = req_reg;
        idx_next       = idx_reg;
        word_next      = word_reg;
        freed_next     = freed_reg;
        mark_addr_next = mark_addr_reg;
        mark_left_next = mark_left_reg;
        mark_val_next  = mark_val_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        run_start_next = run_start_reg;
        run_len_next   = run_len_reg;
        res_next       = res_reg;
        start24        = 24'd0;
        tb_we          = 1'b0;
        tb_waddr       = idx_reg;
        tb_wdata       = 32'd0;
        tb_raddr       = TBL_AW'(in_idx_full);
        fm_we          = 1'b0;
        fm_waddr       = SECT_AW'(mark_addr_reg);
        fm_wdata       = mark_val_reg;
        fm_raddr       = SECT_AW'(scan_idx_reg);

        case (state_reg)
            S_CLR: begin
                if (clr_reg < CLR_W'(MAX_SECTORS)) begin
                    fm_we    = 1'b1;
                    fm_waddr = SECT_AW'(clr_reg);
                    fm_wdata = (clr_reg >= CLR_W'(2));
                end
                if (clr_reg < CLR_W'(TBL_DEPTH)) begin
                    tb_we    = 1'b1;
                    tb_waddr = TBL_AW'(clr_reg);
                    tb_wdata = 32'd0;
                end
                clr_next = clr_reg + CLR_W'(1);
                if (clr_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_valid) begin
                    req_next = in_req;
                    idx_next = TBL_AW'(in_idx_full);
                    if (in_req.req_type == rsa_pkg::REQ_NONE) begin
                        state_next = S_IDLE;
                    end else if (in_oob) begin
                        res_next   = '{rsa_pkg::ST_OOB, 12'd0, 8'd0, 8'd0};
                        state_next = S_RESP;
                    end else begin
                        state_next = S_RD;
                    end
                end
            end

            S_RD: begin
                word_next = tb_rdata;
                case (req_reg.req_type)
                    rsa_pkg::REQ_LOAD: begin
                        tb_we      = 1'b1;
                        tb_wdata   = req_reg.entry_word;
                        res_next   = '{rsa_pkg::ST_LOADED, req_reg.entry_word[19:8],
                                       req_reg.entry_word[7:0], 8'd0};
                        ret_next   = S_RESP;
                        mark_addr_next = FS_W'(req_reg.entry_word[31:8]);
                        mark_left_next = req_reg.entry_word[7:0];
                        mark_val_next  = 1'b0;
                        state_next = ent_ok ? S_MARK : S_RESP;
                    end
                    rsa_pkg::REQ_LOOKUP: begin
                        if (tb_rdata == 32'd0) begin
                            res_next = '{rsa_pkg::ST_MISS, 12'd0, 8'd0, 8'd0};
                        end else if (!old_ok) begin
                            res_next = '{rsa_pkg::ST_INVALID, tb_rdata[19:8], old_cnt, 8'd0};
                        end else begin
                            res_next = '{rsa_pkg::ST_FOUND, tb_rdata[19:8], old_cnt, 8'd0};
                        end
                        state_next = S_RESP;
                    end
                    default: begin
                        if (too_large) begin
                            res_next   = '{rsa_pkg::ST_TOO_LARGE, 12'd0, 8'd0, 8'd0};
                            state_next = S_RESP;
                        end else if (old_start != 24'd0 && old_cnt == needed) begin
                            res_next   = '{rsa_pkg::ST_REWRITE, tb_rdata[19:8], old_cnt, 8'd0};
                            state_next = S_RESP;
                        end else begin
                            // free the old run (if sane), then scan from sector 0
                            freed_next     = old_ok;
                            scan_idx_next  = '0;
                            pend_next      = 1'b0;
                            run_len_next   = 8'd0;
                            ret_next       = S_SCAN;
                            mark_addr_next = FS_W'(old_start);
                            mark_left_next = old_cnt;
                            mark_val_next  = 1'b1;
                            state_next     = old_ok ? S_MARK : S_SCAN;
                        end
                    end
                endcase
            end

            S_MARK: begin
                // one free-map bit per cycle; header sectors stay reserved
                if (mark_left_reg == 8'd0) begin
                    state_next = ret_reg;
                end else begin
                    fm_we          = (mark_addr_reg >= FS_W'(2));
                    mark_addr_next = mark_addr_reg + FS_W'(1);
                    mark_left_next = mark_left_reg - 8'd1;
                end
            end

            S_SCAN: begin
                if (pend_reg && fm_rdata && run_len_c >= {1'b0, needed}) begin
                    // first fit found
                    start24        = 24'(run_start_c);
                    pend_next      = 1'b0;
                    tb_we          = 1'b1;
                    tb_wdata       = {start24, needed};
                    res_next       = '{rsa_pkg::ST_REUSE, start24[11:0], needed, 8'd0};
                    ret_next       = S_RESP;
                    mark_addr_next = run_start_c;
                    mark_left_next = needed;
                    mark_val_next  = 1'b0;
                    state_next     = S_MARK;
                end else if (!pend_reg && scan_idx_reg >= file_reg) begin
                    // no run fits below the end of file
                    ret_next = S_RESP;
                    if (grow_sum > 32'(MAX_SECTORS)) begin
                        res_next       = '{rsa_pkg::ST_NO_SPACE, 12'd0, needed, 8'd0};
                        mark_addr_next = FS_W'(word_reg[31:8]);
                        mark_left_next = word_reg[7:0];
                        mark_val_next  = 1'b0;
                        state_next     = freed_reg ? S_MARK : S_RESP;
                    end else begin
                        start24        = 24'(file_reg);
                        tb_we          = 1'b1;
                        tb_wdata       = {start24, needed};
                        res_next       = '{rsa_pkg::ST_GROW, start24[11:0], needed, needed};
                        file_next      = file_reg + FS_W'(needed);
                        mark_addr_next = file_reg;
                        mark_left_next = needed;
                        mark_val_next  = 1'b0;
                        state_next     = S_MARK;
                    end
                end else begin
                    // track the current run
                    if (pend_reg) begin
                        if (fm_rdata) begin
                            run_start_next = run_start_c;
                            run_len_next   = run_len_c[7:0];
                        end else begin
                            run_len_next = 8'd0;
                        end
                    end
                    // issue the next read
                    if (scan_idx_reg < file_reg) begin
                        pend_next     = 1'b1;
                        pend_idx_next = scan_idx_reg;
                        scan_idx_next = scan_idx_reg + FS_W'(1);
                    end else begin
                        pend_next = 1'b0;
                    end
                end
            end

            S_RESP: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // reopen the region on a config write
        if (cfg_we) begin
            if (cfg_wdata < 13'd2) begin
                file_next = FS_W'(2);
            end else if (32'(cfg_wdata) > 32'(MAX_SECTORS)) begin
                file_next = FS_W'(MAX_SECTORS);
            end else begin
                file_next = FS_W'(cfg_wdata);
            end
            clr_next   = '0;
            state_next = S_CLR;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            file_reg  <= FS_W'(2);
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            file_reg  <= file_next;
            pend_reg  <= pend_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        ret_reg       <= ret_next;
        req_reg       <= req_next;
        idx_reg       <= idx_next;
        word_reg      <= word_next;
        freed_reg     <= freed_next;
        mark_addr_reg <= mark_addr_next;
        mark_left_reg <= mark_left_next;
        mark_val_reg  <= mark_val_next;
        scan_idx_reg  <= scan_idx_next;
        pend_idx_reg  <= pend_idx_next;
        run_start_reg <= run_start_next;
        run_len_reg   <= run_len_next;
        res_reg       <= res_next;
    end

endmodule

FILE: design/region_sector_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the region sector allocator: stream ports, output register,
// offset table and free map RAMs. Depends on rsa_pkg, rsa_ram, rsa_seq.
//
//  channel  | ports                       | beat contents
//  ---------+-----------------------------+--------------------------------------
//  request  | s_tvalid s_tready s_tdata   | x, z, saved word, length; tuser = kind
//           | s_tuser                     |
//  result   | m_tvalid m_tready m_tdata   | start, count, grown; tuser = status
//           | m_tuser                     |
//  config   | cfg_we cfg_wdata            | initial file size in sectors
//
// The free map is scanned one sector per cycle through its read port, and each
// run of sectors is marked one bit per cycle through its write port.
// After reset and after every config write a clearing pass over the free map and the
// offset table runs before a request is taken.
// A request is taken while an earlier result still waits in the output register.
module region_sector_allocator_unit #(
    parameter int MAX_SECTORS = rsa_pkg::MAX_SECTORS,
    parameter int GRID_SIZE   = rsa_pkg::GRID_SIZE
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [12:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // chunk_x[7:0], chunk_z[15:8], entry_word[47:16],
                                   // comp_length[71:48]
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // start_sector[11:0], sector_count[19:12],
                                   // grown_sectors[27:20], zero[31:28]
    output logic [3:0]  m_tuser    // status[3:0]
);

    localparam int TBL_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);
    localparam int SECT_AW   = $clog2(MAX_SECTORS);

    rsa_pkg::req_t       in_req;
    rsa_pkg::res_t       res;
    logic                res_valid;
    logic                res_ready;
    logic                m_tvalid_reg, m_tvalid_next;
    rsa_pkg::res_t       out_reg, out_next;

    logic                tb_we;
    logic [TBL_AW-1:0]   tb_waddr, tb_raddr;
    logic [31:0]         tb_wdata, tb_rdata;
    logic                fm_we, fm_wdata, fm_rdata;
    logic [SECT_AW-1:0]  fm_waddr, fm_raddr;

    // unpack the request beat
    assign in_req.req_type    = s_tuser;
    assign in_req.chunk_x     = s_tdata[7:0];
    assign in_req.chunk_z     = s_tdata[15:8];
    assign in_req.entry_word  = s_tdata[47:16];
    assign in_req.comp_length = s_tdata[71:48];

    rsa_seq #(
        .MAX_SECTORS (MAX_SECTORS),
        .GRID_SIZE   (GRID_SIZE)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_req    (in_req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .tb_we     (tb_we),
        .tb_waddr  (tb_waddr),
        .tb_wdata  (tb_wdata),
        .tb_raddr  (tb_raddr),
        .tb_rdata  (tb_rdata),
        .fm_we     (fm_we),
        .fm_waddr  (fm_waddr),
        .fm_wdata  (fm_wdata),
        .fm_raddr  (fm_raddr),
        .fm_rdata  (fm_rdata)
    );

    rsa_ram #(.WIDTH(32), .DEPTH(TBL_DEPTH)) u_table (
        .aclk  (aclk),
        .we    (tb_we),
        .waddr (tb_waddr),
        .wdata (tb_wdata),
        .raddr (tb_raddr),
        .rdata (tb_rdata)
    );

    rsa_ram #(.WIDTH(1), .DEPTH(MAX_SECTORS)) u_free_map (
        .aclk  (aclk),
        .we    (fm_we),
        .waddr (fm_waddr),
        .wdata (fm_wdata),
        .raddr (fm_raddr),
        .rdata (fm_rdata)
    );

    // output register
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            out_next      = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {4'd0, out_reg.grown_sectors, out_reg.sector_count,
                       out_reg.start_sector};

endmodule

FILE: bench/region_sector_allocator_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for region_sector_allocator_unit: a directed table, then
// random load/lookup/write traffic checked against a behavioral allocator model.
// Depends on rsa_pkg and the design under design/.
module region_sector_allocator_unit_test;
    import rsa_pkg::*;

    localparam int NDIR = 22;
    localparam longint CYCLE_LIMIT = 64'd3000000;

    typedef struct packed {
        logic [3:0]  status;
        logic [11:0] start_sector;
        logic [7:0]  sector_count;
        logic [7:0]  grown_sectors;
    } alloc_res_t;

    // directed row: request plus an optional typed-in result
    typedef struct {
        logic [1:0]  kind;
        logic [7:0]  cx;
        logic [7:0]  cz;
        logic [31:0] word;
        logic [23:0] len;
        bit          fixed;
        alloc_res_t  res;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [12:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    region_sector_allocator_unit dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // allocator shadow state
    logic [31:0] chunk_words [GRID_SIZE*GRID_SIZE];
    bit          sector_free [MAX_SECTORS];
    int unsigned file_len;

    alloc_res_t pending_results[$];
    int   fail_count = 0;
    int   beats_out = 0;
    int   writes_seen = 0;
    longint cycle_count = 0;
    bit   hold_sink = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("MISMATCH %0t %s: got %0h want %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic void reopen_region(input logic [12:0] v);
        int unsigned n;
        n = v;
        if (n < 2) n = 2;
        if (n > MAX_SECTORS) n = MAX_SECTORS;
        foreach (chunk_words[i]) chunk_words[i] = '0;
        foreach (sector_free[i]) sector_free[i] = 1'b1;
        sector_free[0] = 1'b0;
        sector_free[1] = 1'b0;
        file_len = n;
    endfunction

    function automatic bit span_ok(input logic [31:0] w);
        return w != 0 && (longint'(w[31:8]) + w[7:0]) <= file_len;
    endfunction

    function automatic void set_span(input int unsigned st, input int unsigned cnt,
                                     input bit fr);
        int unsigned s;
        for (int unsigned i = 0; i < cnt; i++) begin
            s = st + i;
            if (s >= 2 && s < MAX_SECTORS) sector_free[s] = fr;
        end
    endfunction

    function automatic alloc_res_t mk(input logic [3:0] st, input int unsigned a,
                                      input int unsigned c, input int unsigned g);
        alloc_res_t r;
        r.status = st;
        r.start_sector = a[11:0];
        r.sector_count = c[7:0];
        r.grown_sectors = g[7:0];
        return r;
    endfunction

    // returns 0 when the request yields no result
    function automatic bit allocate_step(input logic [1:0] kind, input logic signed [7:0] cx,
                                         input logic signed [7:0] cz, input logic [31:0] ew,
                                         input logic [23:0] len, output alloc_res_t r);
        int unsigned idx, need, st, cnt, rs, rl;
        logic [31:0] w;
        bit fr;
        if (kind == REQ_NONE) return 0;
        if (cx < 0 || cx >= GRID_SIZE || cz < 0 || cz >= GRID_SIZE) begin
            r = mk(ST_OOB, 0, 0, 0);
            return 1;
        end
        idx = int'(cx) + int'(cz) * GRID_SIZE;
        w = chunk_words[idx];
        if (kind == REQ_LOAD) begin
            chunk_words[idx] = ew;
            if (span_ok(ew)) set_span(ew[31:8], ew[7:0], 1'b0);
            r = mk(ST_LOADED, ew[31:8], ew[7:0], 0);
            return 1;
        end
        if (kind == REQ_LOOKUP) begin
            if (w == 0) r = mk(ST_MISS, 0, 0, 0);
            else if (!span_ok(w)) r = mk(ST_INVALID, w[31:8], w[7:0], 0);
            else r = mk(ST_FOUND, w[31:8], w[7:0], 0);
            return 1;
        end
        need = (int'(len) + HEADER_BYTES) / SECTOR_SIZE + 1;
        if (need >= CNT_LIMIT) begin
            r = mk(ST_TOO_LARGE, 0, 0, 0);
            return 1;
        end
        st = w[31:8];
        cnt = w[7:0];
        if (st != 0 && cnt == need) begin
            r = mk(ST_REWRITE, st, cnt, 0);
            return 1;
        end
        fr = span_ok(w);
        if (fr) set_span(st, cnt, 1'b1);
        rs = 0;
        rl = 0;
        for (int unsigned i = 0; i < file_len && i < MAX_SECTORS; i++) begin
            if (sector_free[i]) begin
                if (rl == 0) rs = i;
                rl++;
                if (rl >= need) break;
            end else begin
                rl = 0;
            end
        end
        if (rl >= need) begin
            set_span(rs, need, 1'b0);
            chunk_words[idx] = (rs << 8) | need;
            r = mk(ST_REUSE, rs, need, 0);
            return 1;
        end
        if (file_len + need > MAX_SECTORS) begin
            if (fr) set_span(st, cnt, 1'b0);
            r = mk(ST_NO_SPACE, 0, need, 0);
            return 1;
        end
        rs = file_len;
        set_span(rs, need, 1'b0);
        file_len += need;
        chunk_words[idx] = (rs << 8) | need;
        r = mk(ST_GROW, rs, need, need);
        return 1;
    endfunction

    // random short gap, occasionally long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 45) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result sink with random stalls
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("region_sector_allocator_unit_test: done, errors");
            $finish;
        end
        if (aresetn && m_tvalid && m_tready) begin
            beats_out <= beats_out + 1;
            if (pending_results.size() == 0) begin
                report("unexpected beat", {m_tuser, m_tdata[27:0]}, '0);
            end else begin
                alloc_res_t e;
                e = pending_results.pop_front();
                if (m_tuser != e.status) report("status", m_tuser, e.status);
                if (m_tdata[11:0] != e.start_sector)
                    report("start_sector", m_tdata[11:0], e.start_sector);
                if (m_tdata[19:12] != e.sector_count)
                    report("sector_count", m_tdata[19:12], e.sector_count);
                if (m_tdata[27:20] != e.grown_sectors)
                    report("grown_sectors", m_tdata[27:20], e.grown_sectors);
            end
        end
        m_tready <= hold_sink ? 1'b0 : ($urandom_range(0, 99) < 70);
    end

    // send one request beat; prediction is done at acceptance
    // valid stays up between beats with no gap; drain drops it before a config write and at the end
    task automatic send_req(input logic [1:0] kind, input logic [7:0] cx, input logic [7:0] cz,
                            input logic [31:0] ew, input logic [23:0] len,
                            input bit fixed, input alloc_res_t want);
        alloc_res_t r;
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {len, ew, cz, cx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (allocate_step(kind, cx, cz, ew, len, r)) begin
            if (fixed && r != want) report("table row vs model", r, want);
            pending_results = {pending_results, (fixed ? want : r)};
        end
        if (kind == REQ_WRITE) writes_seen++;
    endtask

    task automatic drain(input int extra);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_size(input logic [12:0] v);
        drain(2 * MAX_SECTORS + 600);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        reopen_region(v);
    endtask

    // random coordinate, mostly on the grid
    function automatic logic [7:0] pick_coord(input int hot);
        int p;
        p = $urandom_range(0, 99);
        if (p < 8) return 8'($urandom_range(0, 255));
        if (p < 60) return 8'(hot);
        return 8'($urandom_range(0, GRID_SIZE - 1));
    endfunction

    task automatic random_phase(input int n, input int max_len);
        logic [1:0]  k;
        logic [31:0] w;
        logic [23:0] l;
        int p;
        for (int i = 0; i < n; i++) begin
            p = $urandom_range(0, 99);
            k = p < 15 ? REQ_LOAD : p < 40 ? REQ_LOOKUP : p < 95 ? REQ_WRITE : REQ_NONE;
            p = $urandom_range(0, 99);
            if (p < 60)
                w = {24'($urandom_range(2, file_len + 4)), 8'($urandom_range(1, 6))};
            else
                w = $urandom;
            p = $urandom_range(0, 99);
            if (p < 85) l = 24'($urandom_range(0, max_len));
            else if (p < 95) l = 24'($urandom);
            else l = 24'hFFFFFF;
            send_req(k, pick_coord($urandom_range(0, 3)), pick_coord($urandom_range(0, 3)),
                     w, l, 1'b0, '0);
        end
    endtask

    dir_row_t dir_rows [NDIR];

    initial begin
        alloc_res_t none;
        none = '0;
        reopen_region(13'd2);
        // directed rows: kind, x, z, word, length, fixed, result
        dir_rows = '{
            '{REQ_LOOKUP, 8'd0, 8'd0, 32'h0, 24'h0, 1, mk(ST_MISS, 0, 0, 0)},
            '{REQ_LOOKUP, 8'd31, 8'd31, 32'h0, 24'h0, 1, mk(ST_MISS, 0, 0, 0)},
            '{REQ_LOOKUP, 8'd32, 8'd0, 32'h0, 24'h0, 1, mk(ST_OOB, 0, 0, 0)},
            '{REQ_WRITE, 8'hFF, 8'd0, 32'h0, 24'h0, 1, mk(ST_OOB, 0, 0, 0)},
            '{REQ_LOAD, 8'd0, 8'h80, 32'h0, 24'h0, 1, mk(ST_OOB, 0, 0, 0)},
            '{REQ_LOOKUP, 8'd5, 8'h7F, 32'h0, 24'h0, 1, mk(ST_OOB, 0, 0, 0)},
            '{REQ_WRITE, 8'd1, 8'd1, 32'h0, 24'hFFFFFF, 1, mk(ST_TOO_LARGE, 0, 0, 0)},
            '{REQ_WRITE, 8'd1, 8'd1, 32'h0, 24'h0, 1, mk(ST_GROW, 2, 1, 1)},
            '{REQ_WRITE, 8'd1, 8'd1, 32'h0, 24'h0, 1, mk(ST_REWRITE, 2, 1, 0)},
            '{REQ_WRITE, 8'd2, 8'd1, 32'h0, 24'd4088, 1, mk(ST_GROW, 3, 2, 2)},
            '{REQ_NONE, 8'd2, 8'd1, 32'h0, 24'h0, 0, none},
            '{REQ_LOOKUP, 8'd2, 8'd1, 32'h0, 24'h0, 1, mk(ST_FOUND, 3, 2, 0)},
            '{REQ_WRITE, 8'd2, 8'd1, 32'h0, 24'h0, 0, none},
            '{REQ_WRITE, 8'd3, 8'd1, 32'h0, 24'h0, 0, none},
            '{REQ_LOAD, 8'd4, 8'd4, 32'hFFFFFFFF, 24'h0, 1, mk(ST_LOADED, 12'hFFF, 8'hFF, 0)},
            '{REQ_LOOKUP, 8'd4, 8'd4, 32'h0, 24'h0, 1, mk(ST_INVALID, 12'hFFF, 8'hFF, 0)},
            '{REQ_WRITE, 8'd4, 8'd4, 32'h0, 24'd1000000, 0, none},
            '{REQ_LOAD, 8'd6, 8'd6, 32'h00000302, 24'h0, 0, none},
            '{REQ_LOOKUP, 8'd6, 8'd6, 32'h0, 24'h0, 0, none},
            '{REQ_WRITE, 8'd6, 8'd6, 32'h0, 24'd1040368, 0, none},
            '{REQ_LOAD, 8'd7, 8'd0, 32'h0, 24'h0, 1, mk(ST_LOADED, 0, 0, 0)},
            '{REQ_WRITE, 8'd7, 8'd0, 32'h0, 24'd200, 0, none}
        };
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_req(dir_rows[i].kind, dir_rows[i].cx, dir_rows[i].cz, dir_rows[i].word,
                     dir_rows[i].len, dir_rows[i].fixed, dir_rows[i].res);

        // full-size corner: region opened at the maximum size
        write_size(13'h1FFF);
        send_req(REQ_WRITE, 8'd0, 8'd0, 32'h0, 24'd4000, 0, none);
        send_req(REQ_LOAD, 8'd1, 8'd0, 32'h00000201, 24'h0, 0, none);
        send_req(REQ_WRITE, 8'd2, 8'd0, 32'h0, 24'd5000000, 0, none);

        write_size(13'd0);
        random_phase(50, 20000);
        write_size(13'd40);
        random_phase(40, 60000);
        write_size(13'd3000);
        random_phase(25, 400000);

        // end: drain results, then a quiet tail with the sink held off
        drain(200);
        hold_sink = 1'b1;
        repeat (200) @(posedge aclk);
        $display("covered %0d result beats, %0d write requests, sizes 2..4096",
                 beats_out, writes_seen);
        if (fail_count == 0 && pending_results.size() == 0 && !m_tvalid) begin
            $display("region_sector_allocator_unit_test: done, clean");
        end else begin
            $display("region_sector_allocator_unit_test: done, errors");
        end
        $finish;
    end
endmodule
